>>> design/sha_pkg.sv
// sha_pkg: round constants, initial hash values and round functions for the sha-256 hasher
// no dependencies
`default_nettype none
package sha_pkg;
    localparam int unsigned RoundCount = 64;
    typedef logic [31:0] t_word;

    function automatic t_word init_h(input logic [2:0] idx);
        t_word v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    localparam t_word RoundK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
        32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
        32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
        32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
        32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
        32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;
    localparam logic [63:0] BlockBits = 64'd512;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction
    function automatic t_word sig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction
    function automatic t_word sig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction
    function automatic t_word bsig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction
    function automatic t_word bsig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction
endpackage
`default_nettype wire

>>> design/sha256_message_hasher_core.sv
// sha256_message_hasher_core: byte-serial sha-256 hasher, top level
// depends on sha_pkg and sha_ram
//
// usage:
//  - input channel (i_valid/o_ready) carries one word per item: i_msg_byte,
//    i_byte_valid, i_end_of_message
//  - output channel (o_valid/i_ready) gives eight digest words, index 0 first,
//    o_last_word on index 7
//  - bytes go into a 64-byte buffer ram; a byte that does not fill the block
//    is written and the input stays ready
//  - a full block is compressed by one shared round unit: the message schedule
//    is loaded from the buffer ram (one byte per cycle, registered read data),
//    then 64 rounds at one round per cycle, then the chaining add; the input
//    is held off meanwhile
//  - end of message writes 0x80, then zero and length bytes to the end of the
//    buffer and compresses one block, or pads a whole second block and
//    compresses it as well when 56 or more bytes were buffered
//  - a stalled receiver holds the current digest word; the block waits
//  - reset restores the initial hash values, zero fill and zero bit count;
//    the buffer ram needs no clearing since every entry read is written first
`default_nettype none
module sha256_message_hasher_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_ROUND = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_LEN   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [63:0] r_total, n_total;
    logic        r_final, n_final;      // finalization in progress
    logic        r_second, n_second;    // padding carries over into a second block
    logic [6:0]  r_cnt, n_cnt;
    logic [2:0]  r_oidx, n_oidx;
    // set when an input item is accepted, cleared when padding starts or at the chaining add
    logic        r_pend, n_pend;
    sha_pkg::t_word r_h [8];
    sha_pkg::t_word n_h [8];
    sha_pkg::t_word r_v [8];
    sha_pkg::t_word n_v [8];
    sha_pkg::t_word r_w [16];
    sha_pkg::t_word n_w [16];

    // buffer ram
    logic       w_we;
    logic [5:0] w_waddr, w_raddr;
    logic [7:0] w_wdata, w_rdata;

    sha_ram #(.Width(8), .Depth(64)) u_buf (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    sha_pkg::t_word w_t1, w_t2, w_wnew, w_wcur;

    always_comb begin
        w_wcur = r_w[0];
        w_wnew = sha_pkg::sig1(r_w[14]) + r_w[9] + sha_pkg::sig0(r_w[1]) + r_w[0];
        w_t1 = r_v[7] + sha_pkg::bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha_pkg::RoundK[r_cnt[5:0]] + w_wcur;
        w_t2 = sha_pkg::bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2])
             ^ (r_v[1] & r_v[2]));
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    always_comb begin
        n_state = r_state; n_fill = r_fill; n_bits = r_bits; n_total = r_total;
        n_final = r_final; n_second = r_second; n_cnt = r_cnt; n_oidx = r_oidx;
        n_h = r_h; n_v = r_v; n_w = r_w;
        w_we = 1'b0; w_waddr = r_fill; w_wdata = i_msg_byte;
        // loading reads byte r_cnt; byte r_cnt-1 returns this cycle
        w_raddr = r_cnt[5:0];
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_byte_valid) begin
                        w_we = 1'b1;
                        n_fill = r_fill + 6'd1;
                    end
                    n_final = i_end_of_message;
                    if (i_byte_valid && r_fill == 6'd63) begin
                        n_state = S_LOAD;
                        n_cnt = '0;
                        n_second = 1'b0;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // write 0x80 at fill, then zeros / length bytes
                if (r_cnt == 7'd0) begin
                    n_total = r_bits + {55'd0, r_fill, 3'd0};
                    n_second = (r_fill >= sha_pkg::LenStart);
                    w_we = 1'b1; w_waddr = r_fill; w_wdata = sha_pkg::PadByte;
                    n_cnt = {1'b0, r_fill} + 7'd1;
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                // r_cnt: next buffer address to write, 64 means done
                w_we = (r_cnt != 7'd64);
                w_waddr = r_cnt[5:0];
                if (!r_second && r_cnt >= 7'd56)
                    w_wdata = r_total[8'd63 - {r_cnt[2:0], 3'd0} -: 8];
                else
                    w_wdata = 8'd0;
                if (r_cnt == 7'd64) begin
                    n_cnt = '0;
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_LOAD: begin
                // cnt 0..64: address cnt issued, byte cnt-1 shifted in
                // the window moves on when the first byte of a new word arrives
                if (r_cnt != 7'd0) begin
                    n_w[15] = {r_w[15][23:0], w_rdata};
                    if (r_cnt[1:0] == 2'd1) begin
                        for (int k = 0; k < 15; k++) n_w[k] = r_w[k + 1];
                        n_w[15] = {r_w[15][23:0], w_rdata};
                    end
                end
                if (r_cnt == 7'd64) begin
                    n_v = r_h;
                    n_cnt = '0;
                    n_state = S_ROUND;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_ROUND: begin
                n_v[7] = r_v[6]; n_v[6] = r_v[5]; n_v[5] = r_v[4];
                n_v[4] = r_v[3] + w_t1;
                n_v[3] = r_v[2]; n_v[2] = r_v[1]; n_v[1] = r_v[0];
                n_v[0] = w_t1 + w_t2;
                for (int k = 0; k < 15; k++) n_w[k] = r_w[k + 1];
                n_w[15] = w_wnew;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) n_state = S_ADD;
            end
            S_ADD: begin
                for (int k = 0; k < 8; k++) n_h[k] = r_h[k] + r_v[k];
                n_fill = '0;
                n_cnt = '0;
                if (!r_final) begin
                    n_bits = r_bits + sha_pkg::BlockBits;
                    n_state = S_IDLE;
                end else if (r_second) begin
                    // second padding block: zeros then length
                    n_second = 1'b0;
                    n_state = S_LEN;
                end else begin
                    n_state = S_OUT;
                    n_oidx = '0;
                end
                // a block that filled on an end item still needs its padding
                if (r_final && !r_second && r_state == S_ADD && r_pend) begin
                    n_bits = r_bits + sha_pkg::BlockBits;
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        for (int k = 0; k < 8; k++) n_h[k] = sha_pkg::init_h(3'(k));
                        n_bits = '0; n_fill = '0; n_final = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        if (r_state == S_IDLE && i_valid) n_pend = 1'b1;
        else if (r_state == S_PAD) n_pend = 1'b0;
        else if (r_state == S_ADD) n_pend = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_fill <= '0; r_bits <= '0; r_final <= 1'b0;
            r_second <= 1'b0; r_cnt <= '0; r_oidx <= '0; r_pend <= 1'b0;
            for (int k = 0; k < 8; k++) r_h[k] <= sha_pkg::init_h(3'(k));
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_bits <= n_bits; r_final <= n_final;
            r_second <= n_second; r_cnt <= n_cnt; r_oidx <= n_oidx; r_pend <= n_pend;
            r_h <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_v <= n_v;
        r_w <= n_w;
    end

    // the round counter never passes the last round
    a_round_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND |-> r_cnt < 7'd64) else $error("round count overrun");
    // output index advances only on a taken word
    a_oidx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_oidx)) else $error("digest index moved");
    // no input accepted while the digest is being output
    a_no_accept_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input open during output");
endmodule
`default_nettype wire

>>> design/sha_ram.sv
// sha_ram: generic single-port-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module sha_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
